>>> design/fully_assoc_lru_tag_store_assert.svh
// Assertion macros for the LRU tag store.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FULLY_ASSOC_LRU_TAG_STORE_ASSERT_SVH
`define FULLY_ASSOC_LRU_TAG_STORE_ASSERT_SVH

// cons must hold in the same cycle as en
`define FALRU_ASSERT_SAME(label, en, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |-> (cons)) \
        else $error("tag store check failed in the same cycle");

// cons must hold in the cycle after en
`define FALRU_ASSERT_NEXT(label, en, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |=> (cons)) \
        else $error("tag store check failed one cycle later");

`endif

>>> design/falru_pkg.sv
// Shared types and constants of the fully associative LRU tag store.
// No dependencies.
package falru_pkg;

    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int OFS_W      = 4;
    localparam int LIU_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int LINES_DEF  = 64;

    localparam logic [OFS_W-1:0] OFS_RST = 4'd6;
    localparam logic [LIU_W-1:0] LIU_RST = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS  = 2'd0,
        CFG_LINES_IN_USE = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic             miss;
        logic             evicted;
        logic [TAG_W-1:0] evicted_tag;
    } t_lookup;

endpackage

>>> design/falru_cfg.sv
// Configuration registers: line offset and capacity, with capacity clamped to 1..LINES.
// Uses falru_pkg.
module falru_cfg #(
    parameter int LINES = falru_pkg::LINES_DEF,
    parameter int CW    = $clog2(LINES + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [falru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [falru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [falru_pkg::OFS_W-1:0]      o_offset,
    output logic [CW-1:0]                   o_cap
);

    localparam int CMPW = (CW > falru_pkg::LIU_W) ? CW : falru_pkg::LIU_W;

    logic [falru_pkg::OFS_W-1:0] r_offset;
    logic [falru_pkg::LIU_W-1:0] r_liu;
    logic [CMPW-1:0]             cap_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= falru_pkg::OFS_RST;
            r_liu    <= falru_pkg::LIU_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                falru_pkg::CFG_OFFSET_BITS:  r_offset <= i_cfg_data[falru_pkg::OFS_W-1:0];
                falru_pkg::CFG_LINES_IN_USE: r_liu    <= i_cfg_data[falru_pkg::LIU_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above LINES acts as LINES
    always_comb begin
        cap_ext = CMPW'(r_liu);
        if (r_liu == '0) begin
            cap_ext = CMPW'(1);
        end
        if (cap_ext > CMPW'(LINES)) begin
            cap_ext = CMPW'(LINES);
        end
    end

    assign o_offset = r_offset;
    assign o_cap    = cap_ext[CW-1:0];

endmodule

>>> design/falru_array.sv
// Tag CAM with per-line recency ranks and valid bits; one lookup and update per cycle.
// Uses falru_pkg.
module falru_array #(
    parameter int LINES = falru_pkg::LINES_DEF,
    parameter int CW    = $clog2(LINES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [falru_pkg::TAG_W-1:0] i_tag,
    input  logic [CW-1:0]               i_cap,
    output falru_pkg::t_lookup          o_lookup
);

    localparam int IW = $clog2(LINES);

    logic [falru_pkg::TAG_W-1:0] r_tag  [LINES];
    logic [IW-1:0]               r_rank [LINES];
    logic [LINES-1:0]            r_valid;
    logic [CW-1:0]               r_count;

    logic [LINES-1:0]            match;
    logic [LINES-1:0]            victim;
    logic                        hit;
    logic                        full;
    logic                        evict;
    logic                        fill;
    logic [IW-1:0]               hit_rank;
    logic [IW-1:0]               last_rank;
    logic [IW-1:0]               sel_rank;
    logic [IW-1:0]               slot;
    logic [falru_pkg::TAG_W-1:0] ev_tag;
    logic [CW-1:0]               count_m1;

    assign full      = (r_count >= i_cap);
    assign count_m1  = r_count - CW'(1);
    assign last_rank = count_m1[IW-1:0];
    // valid bits are cleared only by reset, so the valid lines are always 0 .. count-1
    assign slot      = r_count[IW-1:0];

    always_comb begin
        hit_rank = '0;
        ev_tag   = '0;
        for (int i = 0; i < LINES; i++) begin
            match[i]  = r_valid[i] && (r_tag[i] == i_tag);
            // the least recent valid line holds the highest rank, count-1
            victim[i] = r_valid[i] && (r_rank[i] == last_rank);
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
        end
        hit   = |match;
        evict = !hit && full;
        fill  = !hit && !full;
        for (int i = 0; i < LINES; i++) begin
            if (evict && victim[i]) begin
                ev_tag = ev_tag | r_tag[i];
            end
        end
        sel_rank = hit ? hit_rank : last_rank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_vld && fill) begin
            r_valid[slot] <= 1'b1;
            r_count       <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            for (int i = 0; i < LINES; i++) begin
                if ((hit && match[i]) || (evict && victim[i]) ||
                    (fill && slot == IW'(i))) begin
                    r_rank[i] <= '0;
                    if (!hit) begin
                        r_tag[i] <= i_tag;
                    end
                end else if (r_valid[i] && (fill || r_rank[i] < sel_rank)) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
        end
    end

    assign o_lookup.miss        = !hit;
    assign o_lookup.evicted     = evict;
    assign o_lookup.evicted_tag = ev_tag;

endmodule

>>> design/fully_assoc_lru_tag_store.sv
// Top level of the fully associative LRU tag store: input register, lookup, result register.
// Uses falru_pkg, falru_cfg, falru_array and the assertion macro header.
//
// One address is taken per clock whenever start is high (busy stays low), and its result
// goes through the input register and the result register to o_valid, high for exactly
// one cycle; the receiver cannot stall, so results must be captured when o_valid is high.
// Throughput is one access per cycle, set by the combinational tag compare and rank update
// over all LINES entries. Configuration may be written only while no access is in flight.
`include "fully_assoc_lru_tag_store_assert.svh"

module fully_assoc_lru_tag_store #(
    parameter int LINES = falru_pkg::LINES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [falru_pkg::ADDR_W-1:0]     i_address,
    input  logic                             i_cfg_we,
    input  logic [falru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [falru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_valid,
    output logic                             o_miss,
    output logic                             o_evicted,
    output logic [falru_pkg::TAG_W-1:0]      o_evicted_tag
);

    localparam int CW = $clog2(LINES + 1);

    logic [falru_pkg::OFS_W-1:0] offset;
    logic [CW-1:0]               cap;
    falru_pkg::t_lookup          lookup;

    logic                        r_in_vld;
    logic [falru_pkg::TAG_W-1:0] r_in_tag;
    logic                        r_out_vld;
    falru_pkg::t_lookup          r_out;

    assign busy = 1'b0;

    falru_cfg #(
        .LINES (LINES),
        .CW    (CW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_offset   (offset),
        .o_cap      (cap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_tag <= i_address >> offset;
        end
    end

    falru_array #(
        .LINES (LINES),
        .CW    (CW)
    ) u_array (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_in_vld),
        .i_tag    (r_in_tag),
        .i_cap    (cap),
        .o_lookup (lookup)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out <= lookup;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_miss        = r_out.miss;
    assign o_evicted     = r_out.evicted;
    assign o_evicted_tag = r_out.evicted_tag;

    // a hit never evicts
    `FALRU_ASSERT_SAME(a_evict_needs_miss, o_valid && o_evicted, o_miss)
    // nothing evicted means a zero tag
    `FALRU_ASSERT_SAME(a_no_evict_zero_tag, o_valid && !o_evicted, o_evicted_tag == '0)
    // every beat in the input register yields one result beat
    `FALRU_ASSERT_NEXT(a_result_follows, r_in_vld, o_valid)

endmodule
